// File: rtl/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg: shared types and constants of the 3x3 box mean filter
// Widths, reset values, reciprocal constants of the mean divider and the
// command and status groups that join controller and datapath.
// ----------------------------------------------------------------------------
package bmf_pkg;

	// Default row store depth (largest image side)
	localparam int MAX_SIZE_DEF = 32;

	// Field widths
	localparam int SIZE_W = 6;
	localparam int PIX_W  = 8;
	localparam int COL_W  = 10;                 // sum of one 3-pixel column
	localparam int SUM_W  = 12;                 // sum of up to nine pixels
	localparam int RECIP_W = 15;
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 16;

	// Image side after reset
	localparam logic [SIZE_W-1:0] IMAGE_SIZE_RESET = 6'd8;

	// Fixed-point reciprocals of the divisors, scaled by 2^RECIP_SHIFT
	localparam logic [RECIP_W-1:0] RECIP_4 = 15'd16384;
	localparam logic [RECIP_W-1:0] RECIP_6 = 15'd10923;
	localparam logic [RECIP_W-1:0] RECIP_9 = 15'd7282;

	// Neighbor count of one result
	typedef enum logic [1:0] {
		DIV_4,
		DIV_6,
		DIV_9
	} div_sel_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic              wr_en;
		logic [1:0]        wr_sel;
		logic [SIZE_W-1:0] wr_col;
		logic              rd_en;
		logic [SIZE_W-1:0] rd_col;
		logic [2:0]        row_en;
		logic              col_en;
		logic              acc_clr;
		logic              mul_en;
		div_sel_t          div_sel;
		logic              out_load;
		logic              out_last;
		logic              out_eoi;
	} bmf_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic out_free;
	} bmf_stat_t;

endpackage

// File: rtl/bmf_row_store.sv
// ----------------------------------------------------------------------------
// bmf_row_store: one image row of pixels
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module bmf_row_store #(
	parameter int DEPTH  = bmf_pkg::MAX_SIZE_DEF,
	parameter int ADDR_W = $clog2(bmf_pkg::MAX_SIZE_DEF)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [ADDR_W-1:0]        wr_addr,
	input  logic [bmf_pkg::PIX_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [ADDR_W-1:0]        rd_addr,
	output logic [bmf_pkg::PIX_W-1:0] rd_data
);
	import bmf_pkg::*;

	logic [PIX_W-1:0] mem_q [DEPTH];
	logic [PIX_W-1:0] rd_data_q;

	// Write one pixel
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read one pixel, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/bmf_datapath.sv
// ----------------------------------------------------------------------------
// bmf_datapath: row stores, neighborhood accumulator, divider, output register
// Reads one column of three rows per cycle, sums the enabled pixels,
// divides by reciprocal multiplication and holds the result for the receiver.
// ----------------------------------------------------------------------------
module bmf_datapath #(
	parameter int MAX_SIZE = bmf_pkg::MAX_SIZE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bmf_pkg::PIX_W-1:0] pixel_in,
	input  bmf_pkg::bmf_cmd_t         cmd,
	output bmf_pkg::bmf_stat_t        stat,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [bmf_pkg::PIX_W-1:0] pixel_out,
	output logic                      last_of_run,
	output logic                      end_of_image
);
	import bmf_pkg::*;

	localparam int ADDR_W = $clog2(MAX_SIZE);

	logic [PIX_W-1:0]  rd_data [3];
	logic              valid_s1;
	logic [2:0]        row_en_s1;
	logic              col_en_s1;
	logic              clr_s1;
	logic [COL_W-1:0]  col_sum;
	logic [SUM_W-1:0]  acc_q;
	logic [RECIP_W-1:0] recip;
	logic [PROD_W-1:0] mul_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  pixel_out_q;
	logic              last_q;
	logic              eoi_q;

	// Three row stores, image row r lives in store r mod 3
	for (genvar g = 0; g < 3; g++) begin : g_store
		bmf_row_store #(
			.DEPTH  (MAX_SIZE),
			.ADDR_W (ADDR_W)
		) u_store (
			.clk     (clk),
			.wr_en   (cmd.wr_en && (cmd.wr_sel == 2'(g))),
			.wr_addr (cmd.wr_col[ADDR_W-1:0]),
			.wr_data (pixel_in),
			.rd_en   (cmd.rd_en),
			.rd_addr (cmd.rd_col[ADDR_W-1:0]),
			.rd_data (rd_data[g])
		);
	end

	// Delay read enables to line up with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		row_en_s1 <= cmd.row_en;
		col_en_s1 <= cmd.col_en;
		clr_s1    <= cmd.acc_clr;
	end

	// Sum the rows of one column that lie inside the image
	always_comb begin
		col_sum = '0;
		for (int k = 0; k < 3; k++) begin
			if (row_en_s1[k]) begin
				col_sum = col_sum + COL_W'(rd_data[k]);
			end
		end
	end

	// Accumulate columns
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_q <= (clr_s1 ? '0 : acc_q) + (col_en_s1 ? SUM_W'(col_sum) : '0);
		end
	end

	// Pick the reciprocal of the neighbor count
	always_comb begin
		case (cmd.div_sel)
			DIV_9:   recip = RECIP_9;
			DIV_6:   recip = RECIP_6;
			default: recip = RECIP_4;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			mul_q <= PROD_W'(acc_q) * PROD_W'(recip);
		end
	end

	// Output register: load a mean, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pixel_out_q <= mul_q[RECIP_SHIFT +: PIX_W];
			last_q      <= cmd.out_last;
			eoi_q       <= cmd.out_eoi;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign pixel_out     = pixel_out_q;
	assign last_of_run   = last_q;
	assign end_of_image  = eoi_q;

endmodule

// File: rtl/bmf_ctrl.sv
// ----------------------------------------------------------------------------
// bmf_ctrl: controller of the 3x3 box mean filter
// Tracks the raster position, writes pixels, and sequences the column reads,
// multiply and output load of every result, including the final-row flush.
// ----------------------------------------------------------------------------
module bmf_ctrl #(
	parameter int MAX_SIZE = bmf_pkg::MAX_SIZE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cfg_wr_en,
	input  logic [bmf_pkg::SIZE_W-1:0] cfg_wr_data,
	input  bmf_pkg::bmf_stat_t         stat,
	output bmf_pkg::bmf_cmd_t          cmd
);
	import bmf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_MUL,
		ST_OUT
	} state_t;

	localparam logic [1:0] COL_LEFT  = 2'd0;
	localparam logic [1:0] COL_RIGHT = 2'd2;

	state_t            state_q;
	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] row_q, col_q;
	logic [1:0]        rowm_q;
	logic [SIZE_W-1:0] rr_q, cc_q, ce_q;
	logic [1:0]        rrm_q;
	logic              flush_q, in_flush_q;
	logic [1:0]        k_q;

	logic [SIZE_W-1:0] size_eff, size_m1;
	logic              wrap, accept, last_px, at_end;
	logic [SIZE_W-1:0] r_in, c_in;
	logic [1:0]        rm_in;
	logic              top_ok, bot_ok, left_ok, right_ok;
	logic [1:0]        top_sel, bot_sel;

	function automatic logic [1:0] mod3_inc(input logic [1:0] v);
		return (v == 2'd2) ? 2'd0 : v + 2'd1;
	endfunction

	function automatic logic [1:0] mod3_dec(input logic [1:0] v);
		return (v == 2'd0) ? 2'd2 : v - 2'd1;
	endfunction

	// Clamp the image side to the supported range
	always_comb begin
		if (size_q < SIZE_W'(2)) begin
			size_eff = SIZE_W'(2);
		end else if (size_q > SIZE_W'(MAX_SIZE)) begin
			size_eff = SIZE_W'(MAX_SIZE);
		end else begin
			size_eff = size_q;
		end
		size_m1 = size_eff - SIZE_W'(1);
	end

	// Position of the incoming pixel, wrapped to the image start if stale
	assign wrap    = (row_q >= size_eff) || (col_q >= size_eff);
	assign r_in    = wrap ? '0 : row_q;
	assign c_in    = wrap ? '0 : col_q;
	assign rm_in   = wrap ? 2'd0 : rowm_q;
	assign in_ready = (state_q == ST_IDLE);
	assign accept  = in_valid && in_ready;
	assign last_px = (r_in == size_m1) && (c_in == size_m1);

	// Neighborhood bounds of the current result
	assign top_ok   = (rr_q != '0);
	assign bot_ok   = (rr_q < size_m1);
	assign left_ok  = (cc_q != '0);
	assign right_ok = (cc_q < size_m1);
	assign top_sel  = mod3_dec(rrm_q);
	assign bot_sel  = mod3_inc(rrm_q);
	assign at_end   = (cc_q == ce_q);

	// State and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			size_q     <= IMAGE_SIZE_RESET;
			row_q      <= '0;
			col_q      <= '0;
			rowm_q     <= 2'd0;
			rr_q       <= '0;
			rrm_q      <= 2'd0;
			cc_q       <= '0;
			ce_q       <= '0;
			flush_q    <= 1'b0;
			in_flush_q <= 1'b0;
			k_q        <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// advance the raster position
						if (c_in == size_m1) begin
							col_q <= '0;
							if (r_in == size_m1) begin
								row_q  <= '0;
								rowm_q <= 2'd0;
							end else begin
								row_q  <= r_in + SIZE_W'(1);
								rowm_q <= mod3_inc(rm_in);
							end
						end else begin
							col_q  <= c_in + SIZE_W'(1);
							row_q  <= r_in;
							rowm_q <= rm_in;
						end
						// results of the previous row become ready
						if ((r_in != '0) && (c_in != '0)) begin
							rr_q       <= r_in - SIZE_W'(1);
							rrm_q      <= mod3_dec(rm_in);
							cc_q       <= c_in - SIZE_W'(1);
							ce_q       <= (c_in == size_m1) ? c_in : c_in - SIZE_W'(1);
							flush_q    <= last_px;
							in_flush_q <= 1'b0;
							k_q        <= 2'd0;
							state_q    <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (k_q == COL_RIGHT) begin
						k_q     <= 2'd0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_WAIT: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (stat.out_free) begin
						if (!at_end) begin
							cc_q    <= cc_q + SIZE_W'(1);
							state_q <= ST_READ;
						end else if (flush_q) begin
							// flush the last row of the image
							rr_q       <= size_m1;
							rrm_q      <= mod3_inc(rrm_q);
							cc_q       <= '0;
							ce_q       <= size_m1;
							flush_q    <= 1'b0;
							in_flush_q <= 1'b1;
							state_q    <= ST_READ;
						end else begin
							in_flush_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// a size write restarts the image
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
				row_q  <= '0;
				col_q  <= '0;
				rowm_q <= 2'd0;
			end
		end
	end

	// Datapath commands
	always_comb begin
		cmd          = '0;
		cmd.div_sel  = DIV_4;
		cmd.wr_en    = accept;
		cmd.wr_sel   = rm_in;
		cmd.wr_col   = c_in;
		case (state_q)
			ST_READ: begin
				cmd.rd_en   = 1'b1;
				cmd.acc_clr = (k_q == COL_LEFT);
				for (int k = 0; k < 3; k++) begin
					cmd.row_en[k] = (2'(k) == rrm_q) ||
						((2'(k) == top_sel) && top_ok) ||
						((2'(k) == bot_sel) && bot_ok);
				end
				if (k_q == COL_LEFT) begin
					cmd.col_en = left_ok;
					cmd.rd_col = left_ok ? cc_q - SIZE_W'(1) : cc_q;
				end else if (k_q == COL_RIGHT) begin
					cmd.col_en = right_ok;
					cmd.rd_col = right_ok ? cc_q + SIZE_W'(1) : cc_q;
				end else begin
					cmd.col_en = 1'b1;
					cmd.rd_col = cc_q;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				if (top_ok && bot_ok && left_ok && right_ok) begin
					cmd.div_sel = DIV_9;
				end else if ((top_ok && bot_ok) || (left_ok && right_ok)) begin
					cmd.div_sel = DIV_6;
				end else begin
					cmd.div_sel = DIV_4;
				end
			end
			ST_OUT: begin
				cmd.out_load = stat.out_free;
				cmd.out_last = at_end && !flush_q;
				cmd.out_eoi  = at_end && in_flush_q;
			end
			default: begin
				cmd.rd_en = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/box_mean_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// box_mean_filter_3x3_unit: 3x3 box mean filter over a square image
// Pixels enter in raster order on the in_valid/in_ready channel; smoothed
// pixels leave on out_valid/out_ready, one row and one column behind.
// Each result is the truncated mean of the neighbors inside the image
// (divide by 4 at corners, 6 at edges, 9 inside). The image's last pixel
// also flushes the whole last row; end_of_image marks its final result and
// last_of_run marks the final result caused by each input item.
// cfg_wr_en/cfg_wr_data set the image side (2 to MAX_SIZE) and restart the
// image; write it only while the block is idle.
// An item that causes no result leaves the input ready. Each result is made
// in steps: three column reads from the row stores (one read port each),
// accumulate, reciprocal multiply and output load; no new item is taken
// until the item's results are done.
// The output register holds a result until taken; a stalled receiver holds
// the next result in the multiply register, and in_ready returns once the item's
// last result is loaded. Reset clears position and output valid, sets the
// side to 8; row stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module box_mean_filter_3x3_unit #(
	parameter int MAX_SIZE = bmf_pkg::MAX_SIZE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bmf_pkg::PIX_W-1:0]  pixel_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bmf_pkg::PIX_W-1:0]  pixel_out,
	output logic                       last_of_run,
	output logic                       end_of_image,
	input  logic                       cfg_wr_en,
	input  logic [bmf_pkg::SIZE_W-1:0] cfg_wr_data
);
	import bmf_pkg::*;

	bmf_cmd_t  cmd;
	bmf_stat_t stat;

	bmf_ctrl #(
		.MAX_SIZE (MAX_SIZE)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.stat        (stat),
		.cmd         (cmd)
	);

	bmf_datapath #(
		.MAX_SIZE (MAX_SIZE)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_in     (pixel_in),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_out    (pixel_out),
		.last_of_run  (last_of_run),
		.end_of_image (end_of_image)
	);

endmodule
